### design/cswa_pkg.sv
// Shared types, constants and table builders for the cosine-sum window block.
package cswa_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 3;
    localparam int LEN_CFG_W  = 18;
    localparam int STEP_W     = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int COEF_W      = 18;                  // Q0.18, unsigned
    localparam int COS_W       = 16;                  // Q1.15, signed
    localparam int TERM_W      = COEF_W + 1 + COS_W;  // signed coef x cos
    localparam int ACC_W       = 36;                  // Q33 window sum
    localparam int ACC_LO_W    = 18;                  // low slice for split multiply
    localparam int PROD_W      = SAMPLE_W + ACC_W;
    localparam int ROUND_SHIFT = 33;
    localparam int RES_W       = PROD_W - ROUND_SHIFT;
    localparam int TERM_IDX_W  = 3;
    localparam int NUM_MODES   = 5;
    localparam int NUM_COEFS   = 5;

    // Parameter defaults
    localparam int DEF_MAX_LENGTH     = 131072;
    localparam int DEF_PHASE_BITS     = 24;
    localparam int DEF_COS_INDEX_BITS = 10;
    localparam int DEF_MAX_TERMS      = 5;
    localparam int QUEUE_DEPTH        = 4;

    // Register reset values
    localparam logic [LEN_CFG_W-1:0] RST_WINDOW_LENGTH = LEN_CFG_W'(1024);
    localparam logic [STEP_W-1:0]    RST_PHASE_STEP    = STEP_W'(16400);
    localparam logic [LEN_CFG_W-1:0] MIN_LENGTH        = LEN_CFG_W'(4);

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [MODE_W-1:0] {
        WM_HANN      = 3'd0,
        WM_HAMMING   = 3'd1,
        WM_BH        = 3'd2,
        WM_FLAT_TOP  = 3'd3,
        WM_FLAT_COS  = 3'd4
    } t_window_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_MODE   = 2'd0,
        CFG_WINDOW_LENGTH = 2'd1,
        CFG_PHASE_STEP    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TERMS,
        BK_DRAIN,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_SUM,
        BK_ROUND,
        BK_OUT
    } t_back_state;

    // Coefficients a_k in Q0.18, one row per mode
    localparam logic [COEF_W-1:0] COEF_TAB [NUM_MODES][NUM_COEFS] = '{
        '{18'd131072, 18'd131072, 18'd0,     18'd0,     18'd0},
        '{18'd141558, 18'd120586, 18'd0,     18'd0,     18'd0},
        '{18'd94044,  18'd128002, 18'd37036, 18'd3062,  18'd0},
        '{18'd56513,  18'd109217, 18'd72683, 18'd21910, 18'd1821},
        '{18'd93262,  18'd127768, 18'd37810, 18'd3304,  18'd0}
    };

    // cos over the first quarter wave, Q15, from an 11-term Taylor series in Q30
    function automatic logic signed [COS_W-1:0] quarter_cos(input int unsigned r,
                                                            input int unsigned idx_bits);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        theta = (longint'(r) * TWO_PI_Q30 + (64'd1 << (idx_bits - 1))) >> idx_bits;
        x2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        sum   = 64'sd1 << 30;
        for (int k = 1; k <= 10; k++) begin
            term = (term * x2) >> 30;
            unique case (k)
                1:       term = term / 2;
                2:       term = term / 12;
                3:       term = term / 30;
                4:       term = term / 56;
                5:       term = term / 90;
                6:       term = term / 132;
                7:       term = term / 182;
                8:       term = term / 240;
                9:       term = term / 306;
                default: term = term / 380;
            endcase
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + (64'sd1 << 14)) >>> 15;
        if (v > 32767) begin
            v = 32767;
        end
        return COS_W'(v);
    endfunction

    // Full-turn entry j, mirrored from the quarter wave
    function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned j,
                                                          input int unsigned idx_bits);
        int unsigned quarter;
        int unsigned q;
        int unsigned r;
        logic signed [COS_W-1:0] v;
        quarter = 1 << (idx_bits - 2);
        q       = j >> (idx_bits - 2);
        r       = j & (quarter - 1);
        unique case (q)
            0:       v = quarter_cos(r, idx_bits);
            1:       v = -quarter_cos(quarter - r, idx_bits);
            2:       v = -quarter_cos(r, idx_bits);
            default: v = quarter_cos(quarter - r, idx_bits);
        endcase
        return v;
    endfunction

endpackage

### design/cswa_queue.sv
// Small register queue between the front and back parts.
module cswa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/cswa_front.sv
// Front part: accepts samples, tracks index and phase, drops out-of-window samples.
module cswa_front #(
    parameter int MAX_LENGTH = cswa_pkg::DEF_MAX_LENGTH,
    parameter int PHASE_BITS = cswa_pkg::DEF_PHASE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [cswa_pkg::LEN_CFG_W-1:0]       i_window_length,
    input  logic [cswa_pkg::STEP_W-1:0]          i_phase_step,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [cswa_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_frame_end,
    input  logic                                 i_q_full,
    output logic                                 o_q_push,
    output logic [cswa_pkg::SAMPLE_W+PHASE_BITS:0] o_q_data
);
    import cswa_pkg::*;

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);

    logic [LEN_W-1:0]      r_index;
    logic [PHASE_BITS-1:0] r_phase;
    logic [LEN_W-1:0]      len_eff;
    logic                  in_window;
    logic                  last;
    logic                  accept;

    // Length clamped to the supported range
    always_comb begin
        priority if (i_window_length < MIN_LENGTH) begin
            len_eff = LEN_W'(MIN_LENGTH);
        end else if (i_window_length > LEN_CFG_W'(MAX_LENGTH)) begin
            len_eff = LEN_W'(MAX_LENGTH);
        end else begin
            len_eff = LEN_W'(i_window_length);
        end
    end

    assign in_window  = (r_index < len_eff);
    assign last       = i_frame_end || (r_index == len_eff - 1'b1);
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept && in_window;
    assign o_q_data   = {i_sample, last, r_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_phase <= '0;
        end else if (accept) begin
            if (i_frame_end) begin
                r_index <= '0;
                r_phase <= '0;
            end else if (in_window) begin
                r_index <= r_index + 1'b1;
                r_phase <= r_phase + PHASE_BITS'(i_phase_step);
            end
        end
    end

endmodule

### design/cswa_back.sv
// Back part: term-by-term window sum, sample multiply, rounding and output register.
module cswa_back #(
    parameter int PHASE_BITS     = cswa_pkg::DEF_PHASE_BITS,
    parameter int COS_INDEX_BITS = cswa_pkg::DEF_COS_INDEX_BITS,
    parameter int MAX_TERMS      = cswa_pkg::DEF_MAX_TERMS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [cswa_pkg::MODE_W-1:0]            i_window_mode,
    input  logic                                   i_q_valid,
    input  logic [cswa_pkg::SAMPLE_W+PHASE_BITS:0] i_q_data,
    output logic                                   o_q_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cswa_pkg::SAMPLE_W-1:0]   o_windowed,
    output logic                                   o_last
);
    import cswa_pkg::*;

    localparam int COS_N = 1 << COS_INDEX_BITS;
    localparam int SH    = PHASE_BITS - COS_INDEX_BITS;
    localparam int K_W   = $clog2(MAX_TERMS);
    localparam logic [PHASE_BITS-1:0] HALF = PHASE_BITS'(1) << (SH - 1);

    typedef logic signed [COS_W-1:0] t_cos_rom [COS_N];

    function automatic t_cos_rom build_rom();
        t_cos_rom rom;
        for (int j = 0; j < COS_N; j++) begin
            rom[j] = cos_entry(j, COS_INDEX_BITS);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_rom();

    t_back_state r_state, n_state;

    logic [K_W-1:0]                r_k;
    logic [PHASE_BITS-1:0]         r_p;
    logic [PHASE_BITS-1:0]         r_base;
    logic signed [SAMPLE_W-1:0]    r_sample;
    logic                          r_last_in;
    logic [MODE_W-1:0]             r_mode;

    // term pipeline: ROM read, coef multiply, accumulate
    logic                          r_s1_vld;
    logic [K_W-1:0]                r_s1_k;
    logic signed [COS_W-1:0]       r_cos;
    logic                          r_s2_vld;
    logic                          r_s2_odd;
    logic signed [TERM_W-1:0]      r_term;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [SAMPLE_W+ACC_LO_W:0]         r_plo;
    logic signed [SAMPLE_W+ACC_W-ACC_LO_W-1:0] r_phi;
    logic signed [PROD_W-1:0]                  r_prod;
    logic signed [SAMPLE_W-1:0]                r_res;

    logic                          r_out_vld;
    logic signed [SAMPLE_W-1:0]    r_windowed;
    logic                          r_last;

    logic                          issue;
    logic                          load_out;
    logic                          out_free;
    logic [PHASE_BITS-1:0]         rounded_p;
    logic [COS_INDEX_BITS-1:0]     rom_idx;
    logic [COEF_W-1:0]             coef;
    logic signed [PROD_W-1:0]      bias;
    logic signed [PROD_W-1:0]      biased;
    logic signed [RES_W-1:0]       res_wide;

    assign out_free  = !r_out_vld || i_out_ready;
    assign rounded_p = r_p + HALF;
    assign rom_idx   = rounded_p[PHASE_BITS-1:SH];
    assign coef      = COEF_TAB[r_mode][TERM_IDX_W'(r_s1_k)];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (i_q_valid) n_state = BK_TERMS;
            BK_TERMS:  if (r_k == K_W'(MAX_TERMS - 1)) n_state = BK_DRAIN;
            BK_DRAIN:  if (!r_s1_vld && !r_s2_vld) n_state = BK_MUL_LO;
            BK_MUL_LO: n_state = BK_MUL_HI;
            BK_MUL_HI: n_state = BK_SUM;
            BK_SUM:    n_state = BK_ROUND;
            BK_ROUND:  n_state = BK_OUT;
            BK_OUT:    if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop  = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE:  o_q_pop  = i_q_valid;
            BK_TERMS: issue    = 1'b1;
            BK_OUT:   load_out = out_free;
            default:  ;
        endcase
    end

    // Round half away from zero in Q33, then saturate
    always_comb begin
        bias     = r_prod[PROD_W-1] ? (PROD_W'(1) <<< (ROUND_SHIFT - 1)) - 1'b1
                                    : (PROD_W'(1) <<< (ROUND_SHIFT - 1));
        biased   = r_prod + bias;
        res_wide = biased[PROD_W-1:ROUND_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sample  <= i_q_data[SAMPLE_W+PHASE_BITS:PHASE_BITS+1];
            r_last_in <= i_q_data[PHASE_BITS];
            r_base    <= i_q_data[PHASE_BITS-1:0];
            r_p       <= '0;
            r_k       <= '0;
            r_acc     <= '0;
            r_mode    <= (i_window_mode > MODE_W'(WM_FLAT_COS)) ? MODE_W'(WM_HANN)
                                                               : i_window_mode;
        end else begin
            if (issue) begin
                r_p <= r_p + r_base;
                r_k <= r_k + 1'b1;
            end
            if (r_s2_vld) begin
                r_acc <= r_s2_odd ? r_acc - ACC_W'(r_term) : r_acc + ACC_W'(r_term);
            end
        end
        if (issue) begin
            r_cos  <= COS_ROM[rom_idx];
            r_s1_k <= r_k;
        end
        if (r_s1_vld) begin
            r_term   <= $signed({1'b0, coef}) * r_cos;
            r_s2_odd <= r_s1_k[0];
        end
        if (r_state == BK_MUL_LO) begin
            r_plo <= r_sample * $signed({1'b0, r_acc[ACC_LO_W-1:0]});
        end
        if (r_state == BK_MUL_HI) begin
            r_phi <= r_sample * $signed(r_acc[ACC_W-1:ACC_LO_W]);
        end
        if (r_state == BK_SUM) begin
            r_prod <= (PROD_W'(r_phi) <<< ACC_LO_W) + PROD_W'(r_plo);
        end
        if (r_state == BK_ROUND) begin
            priority if (res_wide > RES_W'(32767)) begin
                r_res <= SAMPLE_W'(32767);
            end else if (res_wide < -RES_W'(32768)) begin
                r_res <= SAMPLE_W'(-32768);
            end else begin
                r_res <= SAMPLE_W'(res_wide);
            end
        end
        if (load_out) begin
            r_windowed <= r_res;
            r_last     <= r_last_in;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_windowed  = r_windowed;
    assign o_last      = r_last;

endmodule

### design/cosine_sum_window_apply.sv
// Top level: cosine-sum window applied to a sample stream, with config registers.
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_ready       i_sample, i_frame_end
//  out       source     o_out_valid / i_out_ready     o_windowed, o_last
//  cfg       sink       i_cfg_we (no wait)            i_cfg_addr, i_cfg_wdata
//
//  Cycles: the front takes one transaction per cycle while the queue has room; a
//  sample outside the window is dropped there in that cycle. Each kept sample
//  passes through the back part, which reads the single cosine ROM port once
//  per window term, then runs two split multiplies, the sum and the rounding
//  stage.
//  Reset: synchronous, active low. Config returns to Hann / 1024 / 16400, index
//  and phase clear, queue and output register empty. No clearing pass.
//  Stalls: a finished result sits in the output register; the back part waits
//  for it to go, the queue (QUEUE_DEPTH entries) fills, then o_in_ready drops.
module cosine_sum_window_apply #(
    parameter int MAX_LENGTH     = cswa_pkg::DEF_MAX_LENGTH,
    parameter int PHASE_BITS     = cswa_pkg::DEF_PHASE_BITS,
    parameter int COS_INDEX_BITS = cswa_pkg::DEF_COS_INDEX_BITS,
    parameter int MAX_TERMS      = cswa_pkg::DEF_MAX_TERMS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write port
    input  logic                                   i_cfg_we,
    input  logic [cswa_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [cswa_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // sample input
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [cswa_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                   i_frame_end,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cswa_pkg::SAMPLE_W-1:0]   o_windowed,
    output logic                                   o_last
);
    import cswa_pkg::*;

    localparam int Q_W = SAMPLE_W + 1 + PHASE_BITS;   // sample, last, phase

    logic [MODE_W-1:0]    r_window_mode;
    logic [LEN_CFG_W-1:0] r_window_length;
    logic [STEP_W-1:0]    r_phase_step;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    logic [Q_W-1:0] q_push_data;
    logic [Q_W-1:0] q_pop_data;

    // Config registers; writes to an unused index are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode   <= MODE_W'(WM_HANN);
            r_window_length <= RST_WINDOW_LENGTH;
            r_phase_step    <= RST_PHASE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_MODE:   r_window_mode   <= i_cfg_wdata[MODE_W-1:0];
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_wdata[LEN_CFG_W-1:0];
                CFG_PHASE_STEP:    r_phase_step    <= i_cfg_wdata[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // Front: index/phase tracking and window gating
    cswa_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_phase_step    (r_phase_step),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_frame_end     (i_frame_end),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_data        (q_push_data)
    );

    // Decoupling queue
    cswa_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_pop_data  (q_pop_data)
    );

    // Back: window value, multiply, round, output register
    cswa_back #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_INDEX_BITS (COS_INDEX_BITS),
        .MAX_TERMS      (MAX_TERMS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_mode (r_window_mode),
        .i_q_valid     (q_valid),
        .i_q_data      (q_pop_data),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_windowed    (o_windowed),
        .o_last        (o_last)
    );

    // Queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("queue push while full");

    // Back part only pops a queue that holds an entry
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    // Every queued entry comes from an accepted input transaction
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_in_valid && o_in_ready))
        else $error("queue push without input transaction");

    // A pop takes the back part out of idle for a full item
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back part popped twice in a row");

endmodule
